// ----- hdl/urlqs_pkg.sv -----
// ----------------------------------------------------------------------------
// urlqs_pkg
// Shared types and character codes for the request target splitter.
// ----------------------------------------------------------------------------
package urlqs_pkg;

    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_FRAG  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        RG_PATH  = 2'd0,
        RG_KEY   = 2'd1,
        RG_VALUE = 2'd2,
        RG_FRAG  = 2'd3
    } region_t;

    // classified character as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_query;
        logic       is_frag;
        logic       is_amp;
        logic       is_eq;
        logic       last;
    } item_t;

endpackage

// ----- hdl/urlqs_front.sv -----
// ----------------------------------------------------------------------------
// urlqs_front
// Accepts input beats and decodes the separator characters into flags.
// ----------------------------------------------------------------------------
module urlqs_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_byte,
    input  logic                s_in_last,
    output logic                item_valid,
    input  logic                item_ready,
    output urlqs_pkg::item_t    item
);

    logic             valid_reg;
    logic             valid_next;
    urlqs_pkg::item_t item_reg;
    urlqs_pkg::item_t item_next;
    logic             take;

    assign s_ready    = !valid_reg || item_ready;
    assign take       = s_valid && s_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        item_next.data     = s_in_byte;
        item_next.is_query = (s_in_byte == urlqs_pkg::CH_QUERY);
        item_next.is_frag  = (s_in_byte == urlqs_pkg::CH_FRAG);
        item_next.is_amp   = (s_in_byte == urlqs_pkg::CH_AMP);
        item_next.is_eq    = (s_in_byte == urlqs_pkg::CH_EQ);
        item_next.last     = s_in_last;
        if (take) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (take) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- hdl/urlqs_queue.sv -----
// ----------------------------------------------------------------------------
// urlqs_queue
// Small fifo of classified characters between the front and back parts.
// ----------------------------------------------------------------------------
module urlqs_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  urlqs_pkg::item_t    wr_item,
    output logic                rd_valid,
    input  logic                rd_ready,
    output urlqs_pkg::item_t    rd_item
);

    localparam int CntW = $clog2(urlqs_pkg::QUEUE_DEPTH + 1);

    urlqs_pkg::item_t              mem [urlqs_pkg::QUEUE_DEPTH];
    logic [urlqs_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [urlqs_pkg::QUEUE_AW-1:0] wr_ptr_next;
    logic [urlqs_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [urlqs_pkg::QUEUE_AW-1:0] rd_ptr_next;
    logic [CntW-1:0]                count_reg;
    logic [CntW-1:0]                count_next;
    logic                           push;
    logic                           pop;

    assign wr_ready = (count_reg != CntW'(urlqs_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == urlqs_pkg::QUEUE_AW'(urlqs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == urlqs_pkg::QUEUE_AW'(urlqs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- hdl/urlqs_back.sv -----
// ----------------------------------------------------------------------------
// urlqs_back
// Region tracking state and registered result beat.
// ----------------------------------------------------------------------------
module urlqs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    output logic                item_ready,
    input  urlqs_pkg::item_t    item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic [1:0]          m_part,
    output logic                m_has_byte,
    output logic                m_pair_end,
    output logic                m_error,
    output logic                m_out_last
);

    urlqs_pkg::region_t region_reg;
    urlqs_pkg::region_t region_next;
    logic               query_seen_reg;
    logic               query_seen_next;
    logic               pair_open_reg;
    logic               pair_open_next;
    logic               failed_reg;
    logic               failed_next;

    logic               m_valid_reg;
    logic               m_valid_next;
    logic [7:0]         out_byte_reg;
    logic [7:0]         out_byte_next;
    logic [1:0]         part_reg;
    logic [1:0]         part_next;
    logic               has_byte_reg;
    logic               has_byte_next;
    logic               pair_end_reg;
    logic               pair_end_next;
    logic               error_reg;
    logic               error_next;
    logic               out_last_reg;

    logic               pop;

    assign item_ready = !m_valid_reg || m_ready;
    assign pop        = item_valid && item_ready;

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_part     = part_reg;
    assign m_has_byte = has_byte_reg;
    assign m_pair_end = pair_end_reg;
    assign m_error    = error_reg;
    assign m_out_last = out_last_reg;

    always_comb begin
        region_next     = region_reg;
        query_seen_next = query_seen_reg;
        pair_open_next  = pair_open_reg;
        failed_next     = failed_reg;
        out_byte_next   = 8'd0;
        has_byte_next   = 1'b0;
        pair_end_next   = 1'b0;
        error_next      = 1'b0;
        part_next       = urlqs_pkg::RG_PATH;

        if (failed_reg) begin
            error_next = 1'b1;
        end else begin
            case (region_reg)
                urlqs_pkg::RG_PATH: begin
                    if (item.is_query) begin
                        region_next     = urlqs_pkg::RG_KEY;
                        query_seen_next = 1'b1;
                        pair_open_next  = 1'b0;
                    end else if (item.is_frag) begin
                        region_next = urlqs_pkg::RG_FRAG;
                    end else begin
                        out_byte_next = item.data;
                        has_byte_next = 1'b1;
                    end
                    part_next = region_next;
                end
                urlqs_pkg::RG_FRAG: begin
                    // '?' after a fragment with no query rejects the target
                    if (item.is_query && !query_seen_reg) begin
                        failed_next = 1'b1;
                        error_next  = 1'b1;
                    end else begin
                        out_byte_next = item.data;
                        has_byte_next = 1'b1;
                        part_next     = urlqs_pkg::RG_FRAG;
                    end
                end
                default: begin
                    if (item.is_frag) begin
                        pair_end_next  = pair_open_reg;
                        pair_open_next = 1'b0;
                        region_next    = urlqs_pkg::RG_FRAG;
                    end else if (item.is_amp) begin
                        pair_end_next  = 1'b1;
                        pair_open_next = 1'b0;
                        region_next    = urlqs_pkg::RG_KEY;
                    end else if (item.is_eq && region_reg == urlqs_pkg::RG_KEY) begin
                        pair_open_next = 1'b1;
                        region_next    = urlqs_pkg::RG_VALUE;
                    end else begin
                        pair_open_next = 1'b1;
                        out_byte_next  = item.data;
                        has_byte_next  = 1'b1;
                    end
                    // query closed by end of target with an open pair
                    if (item.last && pair_open_next &&
                        (region_next == urlqs_pkg::RG_KEY ||
                         region_next == urlqs_pkg::RG_VALUE)) begin
                        pair_end_next = 1'b1;
                    end
                    part_next = region_next;
                end
            endcase
        end

        if (item.last) begin
            region_next     = urlqs_pkg::RG_PATH;
            query_seen_next = 1'b0;
            pair_open_next  = 1'b0;
            failed_next     = 1'b0;
        end

        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg     <= urlqs_pkg::RG_PATH;
            query_seen_reg <= 1'b0;
            pair_open_reg  <= 1'b0;
            failed_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                region_reg     <= region_next;
                query_seen_reg <= query_seen_next;
                pair_open_reg  <= pair_open_next;
                failed_reg     <= failed_next;
            end
        end
        if (pop) begin
            out_byte_reg <= out_byte_next;
            part_reg     <= part_next;
            has_byte_reg <= has_byte_next;
            pair_end_reg <= pair_end_next;
            error_reg    <= error_next;
            out_last_reg <= item.last;
        end
    end

endmodule

// ----- hdl/url_target_query_splitter_unit.sv -----
// an accepted input beat passes the front register, the queue and the back result register to m_valid
// throughput: one beat per cycle when the output is not stalled, set by the region update in the back part
// the front register and a two-entry queue let input and output stall independently
// reset: synchronous active-low aresetn empties all stages and returns the region
// state to path with no query seen, no open pair and no error
module url_target_query_splitter_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_part,
    output logic       m_has_byte,
    output logic       m_pair_end,
    output logic       m_error,
    output logic       m_out_last
);

    logic             front_valid;
    logic             front_ready;
    urlqs_pkg::item_t front_item;
    logic             queue_valid;
    logic             queue_ready;
    urlqs_pkg::item_t queue_item;

    urlqs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    urlqs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_item)
    );

    urlqs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_part     (m_part),
        .m_has_byte (m_has_byte),
        .m_pair_end (m_pair_end),
        .m_error    (m_error),
        .m_out_last (m_out_last)
    );

endmodule

// ----- sim/urlqs_checker.sv -----
// ----------------------------------------------------------------------------
// urlqs_checker
// Watches both channels of the request target splitter. Every input beat is
// classified by a local model of the region tracker, and every result beat
// is compared field by field against the oldest classification waiting.
// ----------------------------------------------------------------------------
module urlqs_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic [1:0] m_part,
    input  logic       m_has_byte,
    input  logic       m_pair_end,
    input  logic       m_error,
    input  logic       m_out_last,
    output int         err_cnt,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]         chr;
        urlqs_pkg::region_t part;
        logic               has_byte;
        logic               pair_end;
        logic               error;
        logic               last;
    } split_res_t;

    urlqs_pkg::region_t cur_region;
    logic               query_open;
    logic               pair_live;
    logic               rejected;
    split_res_t         tag_q[$];
    int                 errs = 0;

    // label one byte and advance the tracker
    function automatic split_res_t split_byte(input logic [7:0] b, input logic last);
        split_res_t r;
        r = '{chr: 8'h00, part: urlqs_pkg::RG_PATH, has_byte: 1'b0, pair_end: 1'b0,
              error: 1'b0, last: last};
        if (rejected) begin
            r.error = 1'b1;
        end else if (cur_region == urlqs_pkg::RG_PATH) begin
            if (b == urlqs_pkg::CH_QUERY) begin
                cur_region = urlqs_pkg::RG_KEY;
                query_open = 1'b1;
                pair_live  = 1'b0;
            end else if (b == urlqs_pkg::CH_FRAG) begin
                cur_region = urlqs_pkg::RG_FRAG;
            end else begin
                r.chr      = b;
                r.has_byte = 1'b1;
            end
            r.part = cur_region;
        end else if (cur_region == urlqs_pkg::RG_FRAG) begin
            if (b == urlqs_pkg::CH_QUERY && !query_open) begin
                rejected = 1'b1;
                r.error  = 1'b1;
            end else begin
                r.chr      = b;
                r.has_byte = 1'b1;
                r.part     = urlqs_pkg::RG_FRAG;
            end
        end else begin
            if (b == urlqs_pkg::CH_FRAG) begin
                r.pair_end = pair_live;
                pair_live  = 1'b0;
                cur_region = urlqs_pkg::RG_FRAG;
            end else if (b == urlqs_pkg::CH_AMP) begin
                r.pair_end = 1'b1;
                pair_live  = 1'b0;
                cur_region = urlqs_pkg::RG_KEY;
            end else if (b == urlqs_pkg::CH_EQ && cur_region == urlqs_pkg::RG_KEY) begin
                pair_live  = 1'b1;
                cur_region = urlqs_pkg::RG_VALUE;
            end else begin
                pair_live  = 1'b1;
                r.chr      = b;
                r.has_byte = 1'b1;
            end
            // query closed by the end of the target
            if (last && cur_region != urlqs_pkg::RG_FRAG && pair_live)
                r.pair_end = 1'b1;
            r.part = cur_region;
        end
        if (last) begin
            cur_region = urlqs_pkg::RG_PATH;
            query_open = 1'b0;
            pair_live  = 1'b0;
            rejected   = 1'b0;
        end
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            errs++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        split_res_t want;
        if (!aresetn) begin
            cur_region = urlqs_pkg::RG_PATH;
            query_open = 1'b0;
            pair_live  = 1'b0;
            rejected   = 1'b0;
            tag_q.delete();
        end else begin
            if (s_valid && s_ready)
                tag_q.push_back(split_byte(s_in_byte, s_in_last));
            if (m_valid && m_ready) begin
                if (tag_q.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result beat, expected none, got byte %0h part %0d",
                             $time, m_out_byte, m_part);
                end else begin
                    want = tag_q.pop_front();
                    compare_field("out_byte", want.chr, m_out_byte);
                    compare_field("part", 8'(want.part), 8'(m_part));
                    compare_field("has_byte", 8'(want.has_byte), 8'(m_has_byte));
                    compare_field("pair_end", 8'(want.pair_end), 8'(m_pair_end));
                    compare_field("error", 8'(want.error), 8'(m_error));
                    compare_field("out_last", 8'(want.last), 8'(m_out_last));
                end
            end
        end
        pending <= tag_q.size();
        err_cnt <= errs;
    end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Feeds request targets into the splitter: a few hand-picked targets, then
// random well-formed targets, fragment-before-query rejects and raw noise,
// with bursty input and a wandering output stall pattern.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 150000;
    localparam int BEAT_GOAL   = 640;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_LONG} rdy_mode_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic [7:0] s_in_byte  = 8'h00;
    logic       s_in_last  = 1'b0;
    logic       m_ready    = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_byte;
    logic [1:0] m_part;
    logic       m_has_byte;
    logic       m_pair_end;
    logic       m_error;
    logic       m_out_last;
    int         err_cnt;
    int         pending;

    int unsigned cycle_cnt = 0;
    int          beats_sent = 0;
    int          burst_left = 0;
    logic        steady = 1'b0;
    logic [7:0]  tgt_q[$];
    rdy_mode_t   rdy_mode = RDY_ALWAYS;
    int          rdy_timer = 0;
    int          stall_left = 0;

    url_target_query_splitter_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_part     (m_part),
        .m_has_byte (m_has_byte),
        .m_pair_end (m_pair_end),
        .m_error    (m_error),
        .m_out_last (m_out_last)
    );

    urlqs_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_part     (m_part),
        .m_has_byte (m_has_byte),
        .m_pair_end (m_pair_end),
        .m_error    (m_error),
        .m_out_last (m_out_last),
        .err_cnt    (err_cnt),
        .pending    (pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // output stall pattern, switches mode every so often
    always @(posedge aclk) begin
        if (rdy_timer == 0) begin
            rdy_mode  <= rdy_mode_t'($urandom_range(0, 2));
            rdy_timer <= $urandom_range(20, 150);
        end else begin
            rdy_timer <= rdy_timer - 1;
        end
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            case (rdy_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_COIN:   m_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        m_ready    <= 1'b0;
                        stall_left <= $urandom_range(4, 15);
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
            c = 8'($urandom_range(0, 255));
        else
            c = 8'($urandom_range(32, 126));
        while (c == urlqs_pkg::CH_QUERY || c == urlqs_pkg::CH_FRAG ||
               c == urlqs_pkg::CH_AMP || c == urlqs_pkg::CH_EQ)
            c = 8'($urandom_range(32, 126));
        return c;
    endfunction

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 6))
            0: return urlqs_pkg::CH_QUERY;
            1: return urlqs_pkg::CH_FRAG;
            2: return urlqs_pkg::CH_AMP;
            3: return urlqs_pkg::CH_EQ;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_plain(input int n);
        repeat (n) tgt_q.push_back(plain_char());
    endfunction

    // path, optional query of pairs, optional fragment
    function automatic void build_wellformed();
        int npairs;
        tgt_q.delete();
        add_plain($urandom_range(0, 4));
        if ($urandom_range(0, 3) != 0) begin
            tgt_q.push_back(urlqs_pkg::CH_QUERY);
            npairs = $urandom_range(0, 3);
            for (int p = 0; p < npairs; p++) begin
                if (p != 0)
                    tgt_q.push_back(urlqs_pkg::CH_AMP);
                add_plain($urandom_range(0, 3));
                if ($urandom_range(0, 9) < 7) begin
                    tgt_q.push_back(urlqs_pkg::CH_EQ);
                    add_plain($urandom_range(0, 2));
                    if ($urandom_range(0, 4) == 0) begin
                        tgt_q.push_back(urlqs_pkg::CH_EQ);
                        add_plain($urandom_range(0, 2));
                    end
                end
            end
            if ($urandom_range(0, 5) == 0)
                tgt_q.push_back(urlqs_pkg::CH_AMP);
        end
        if ($urandom_range(0, 4) < 2) begin
            tgt_q.push_back(urlqs_pkg::CH_FRAG);
            add_plain($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0)
                tgt_q.push_back(any_char());
        end
        if (tgt_q.size() == 0)
            tgt_q.push_back(plain_char());
    endfunction

    // fragment marker first, then a question mark: rejected target
    function automatic void build_hash_first();
        tgt_q.delete();
        add_plain($urandom_range(0, 3));
        tgt_q.push_back(urlqs_pkg::CH_FRAG);
        add_plain($urandom_range(0, 3));
        tgt_q.push_back(urlqs_pkg::CH_QUERY);
        repeat ($urandom_range(0, 4)) tgt_q.push_back(any_char());
    endfunction

    function automatic void build_noise();
        tgt_q.delete();
        repeat ($urandom_range(1, 8)) tgt_q.push_back(any_char());
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_target();
        for (int i = 0; i < tgt_q.size(); i++)
            send_beat(tgt_q[i], i == tgt_q.size() - 1);
    endtask

    task automatic send_text(input string txt);
        tgt_q.delete();
        for (int i = 0; i < txt.len(); i++)
            tgt_q.push_back(txt[i]);
        send_target();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int iter;
        int pick;
        iter = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // byte extremes in the path, empty pairs, lone '=', extra '=' in a value,
        // late question mark in the fragment
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_text("p?k=v=w&&=&x#f?#");
        // question mark in the fragment before any query
        send_text("#a?zz");
        // query closed by the end of the target
        send_text("?ab");

        while (beats_sent < BEAT_GOAL) begin
            iter++;
            steady = (iter >= 100 && iter < 130);
            if (iter == 60)
                drain();
            pick = $urandom_range(0, 19);
            if (pick < 14)
                build_wellformed();
            else if (pick < 17)
                build_hash_first();
            else
                build_noise();
            send_target();
        end

        drain();
        repeat (10) @(posedge aclk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/urlqs_pkg.sv
hdl/urlqs_front.sv
hdl/urlqs_queue.sv
hdl/urlqs_back.sv
hdl/url_target_query_splitter_unit.sv
sim/urlqs_checker.sv
sim/tb_top.sv
